>>> rtl/dusi_pkg.sv
// Package for the descending unique sorted insertion list.
// Holds the capacity, field widths, status codes and the cell interface types.
// No dependencies.
`default_nettype none
package dusi_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_READ_OOR  = 3'd4
  } status_t;

  // Control that the top level hands to every cell.
  typedef struct packed {
    logic wr_en;
    logic valid;
  } cell_ctl_t;

  // Flags that a cell reports to the top level and to its right neighbor.
  typedef struct packed {
    logic below;
    logic eq;
  } cell_flags_t;

endpackage
`default_nettype wire

>>> rtl/dusi_cell.sv
// One cell of the sorted list: holds one entry and compares it with the key.
// Depends on dusi_pkg.
`default_nettype none
module dusi_cell
  import dusi_pkg::*;
(
  input  wire logic                      clk,
  input  wire cell_ctl_t                 ctl,
  input  wire logic signed [VALUE_W-1:0] key,
  input  wire logic signed [VALUE_W-1:0] left_entry,
  input  wire cell_flags_t               left_flags,
  output logic signed [VALUE_W-1:0]      entry,
  output cell_flags_t                    flags
);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;

  // The key belongs at or before this cell when the cell is empty or smaller.
  assign flags.below = !ctl.valid || (key > entry_r);
  assign flags.eq    = ctl.valid && (key == entry_r);
  assign entry       = entry_r;

  always_comb begin
    priority if (left_flags.below) begin
      entry_nxt = left_entry;
    end else if (flags.below) begin
      entry_nxt = key;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_r <= entry_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/descending_unique_sorted_insert.sv
// Top level of the descending unique sorted insertion list.
// Instantiates a row of dusi_cell and the result register; uses dusi_pkg.
//
//   channel  direction  tdata fields (low bit up)              tuser
//   in_      slave      value[31:0], position[37:32]           kind
//   out_     master     status[2:0], read_value[34:3],         none
//                       count[41:35]
//
// One beat is taken per clock cycle while the result register can take it.
// Every cell compares its entry with the incoming value in parallel, and the
// whole row shifts in the same edge that loads the result register, so the
// next item can follow at once. Reset clears the entry count and the result
// valid flag; the cells need no clearing. A stalled result holds in the output
// register and blocks the input until it is taken.
`default_nettype none
module descending_unique_sorted_insert
  import dusi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // value[31:0], position[37:32]
  input  wire logic                  in_tuser,   // kind: 0 insert, 1 read
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // status, read_value, count
);

  logic signed [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]          in_pos;
  logic                      accept;
  logic                      is_read;

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  status_t                   status_r;
  logic signed [VALUE_W-1:0] rd_value_r;

  cell_ctl_t                 ctl   [CAPACITY];
  cell_flags_t               flags [CAPACITY];
  logic signed [VALUE_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]       eq_vec;
  logic [CAPACITY-1:0]       sel_vec;

  logic                      dup;
  logic                      full;
  logic                      do_write;
  logic                      read_ok;
  logic signed [VALUE_W-1:0] read_word;
  status_t                   status_nxt;

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_pos   = in_tdata[VALUE_W+POS_W-1:VALUE_W];
  assign is_read  = in_tuser;

  // The result register parts the two sides: a new beat enters whenever the
  // register is empty or its beat leaves in the same cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign dup      = |eq_vec;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign do_write = accept && !is_read && !dup && !full;
  assign read_ok  = |sel_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctl[i].valid = (count_r > CNT_W'(i));
    assign ctl[i].wr_en = do_write;
    assign eq_vec[i]    = flags[i].eq;
    assign sel_vec[i]   = ctl[i].valid && (int'(in_pos) == i);

    if (i == 0) begin : g_head
      // The head cell has no left neighbor, so nothing shifts into it.
      dusi_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .key        (in_value),
        .left_entry (in_value),
        .left_flags ('0),
        .entry      (entry[i]),
        .flags      (flags[i])
      );
    end else begin : g_body
      dusi_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[i]),
        .key        (in_value),
        .left_entry (entry[i-1]),
        .left_flags (flags[i-1]),
        .entry      (entry[i]),
        .flags      (flags[i])
      );
    end
  end

  // At most one cell matches the position, so an AND-OR picks its entry.
  always_comb begin
    read_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_word = read_word | (sel_vec[i] ? entry[i] : '0);
    end
  end

  always_comb begin
    priority if (is_read) begin
      status_nxt = read_ok ? ST_READ_OK : ST_READ_OOR;
    end else if (dup) begin
      // A value already present reports a duplicate even in a full list.
      status_nxt = ST_DUPLICATE;
    end else if (full) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_INSERTED;
    end
  end

  assign count_nxt = do_write ? count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      rd_value_r <= (is_read && read_ok) ? read_word : '0;
    end
  end

  // The count field follows the register, which holds the count after the
  // item in the result register, as no other item has been taken since.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-STATUS_W-VALUE_W-COUNT_W){1'b0}},
                       COUNT_W'(count_r), rd_value_r, status_r};

endmodule
`default_nettype wire

>>> rtl/dusi_checker.sv
// Port-level checker for descending_unique_sorted_insert, with its bind.
// Depends on dusi_pkg.
`default_nettype none
module dusi_checker
  import dusi_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [IN_DATA_W-1:0]  in_tdata,
  input wire logic                  in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  logic [STATUS_W-1:0] st;
  logic [VALUE_W-1:0]  rv;
  logic [COUNT_W-1:0]  cnt;

  assign st  = out_tdata[STATUS_W-1:0];
  assign rv  = out_tdata[STATUS_W+VALUE_W-1:STATUS_W];
  assign cnt = out_tdata[STATUS_W+VALUE_W+COUNT_W-1:STATUS_W+VALUE_W];

  // A result that waits holds its beat.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // An input beat that waits is held by the sender.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("waiting input beat changed");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Only a successful read carries a nonzero value.
  a_rdzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_READ_OK |-> rv == '0)
    else $error("read value not zero");

  // A full rejection only appears at capacity.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_FULL |-> cnt == COUNT_W'(CAPACITY))
    else $error("full reported below capacity");

endmodule

bind descending_unique_sorted_insert dusi_checker u_dusi_checker (.*);
`default_nettype wire
